>>> hdl/tac_pkg.sv
// ----------------------------------------------------------------------------
// Tripwire alarm command controller package
// Shared types, widths, character codes and reset values.
// ----------------------------------------------------------------------------
package tac_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int LEVEL_W     = 10;
  localparam int PERIOD_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int NUM_W       = 14;
  localparam int POS_W       = 5;
  localparam int CLOCK_W     = 12;
  localparam int CHAR_W      = 8;

  localparam int DIGIT_LIMIT_DEFAULT = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEVEL_W-1:0]  MARGIN_RESET = LEVEL_W'(40);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1500);
  localparam logic [NUM_W-1:0]    START_RESET  = NUM_W'(2000);
  localparam logic [NUM_W-1:0]    END_RESET    = NUM_W'(500);
  localparam logic [NUM_W-1:0]    MIDNIGHT     = NUM_W'(2400);
  localparam int                  HOUR_SCALE   = 100;
  localparam int                  CLOCK_MAX    = 4095;
  localparam logic [NUM_W-1:0]    NUM_SAT      = {NUM_W{1'b1}};
  localparam logic [POS_W-1:0]    POS_SAT      = {POS_W{1'b1}};

  localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_MIDDLE = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LATE   = POS_W'(12);

  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
  localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h74;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASELINE = 2'd0,
    CFG_MARGIN   = 2'd1,
    CFG_PERIOD   = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    MODE_DEMO     = 2'd0,
    MODE_ARMED    = 2'd1,
    MODE_DISARMED = 2'd2,
    MODE_AUTO     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ALERT_NONE  = 2'd0,
    ALERT_DEMO  = 2'd1,
    ALERT_ARMED = 2'd2,
    ALERT_AUTO  = 2'd3
  } alert_e;

  typedef enum logic [1:0] {
    PH_WORD   = 2'd0,
    PH_HOUR   = 2'd1,
    PH_MINUTE = 2'd2,
    PH_SECOND = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    BC_NONE,
    BC_COLON,
    BC_COMMA,
    BC_DIGIT,
    BC_OTHER
  } byte_class_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] light_sample;
    logic                   byte_valid;
    logic [CHAR_W-1:0]      rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       beam_broken;
    logic [1:0] alert_kind;
    logic       time_request;
    logic       command_error;
    logic       help_request;
    logic [1:0] alarm_mode;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] light_sample;
    byte_class_e            cls;
    logic [CHAR_W-1:0]      rx_byte;
    logic [3:0]             digit;
  } q_entry_t;

endpackage

>>> hdl/tripwire_alarm_command_controller.sv
// ----------------------------------------------------------------------------
// Tripwire alarm command controller
// Per-tick beam check, command parsing and alarm mode control.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the queue, and the tick unit then writes its
// result to the output register.
// Throughput: one item per cycle while the output is not stalled; the tick unit sets the rate.
// Reset: asynchronous and active low; it empties the queue and output
// register and restores all state and configuration at once, no clearing pass.
module tripwire_alarm_command_controller #(
  parameter int DIGIT_LIMIT = tac_pkg::DIGIT_LIMIT_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tac_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [tac_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tac_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tac_pkg::out_item_t              out_data_o
);
  import tac_pkg::*;

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_data;

  tac_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  tac_back #(
    .DIGIT_LIMIT (DIGIT_LIMIT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // The tick unit only takes an item the queue actually holds.
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("tick unit popped an empty queue");

  // A full queue always presents an item at its head.
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_valid)
    else $error("queue reports full with no head item");

  // A waiting result is never overwritten by the next tick.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !q_pop)
    else $error("result overwritten while stalled");

  // Every tick yields a result in the following cycle.
  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o)
    else $error("tick produced no result");
`endif

endmodule

>>> hdl/tac_front.sv
// ----------------------------------------------------------------------------
// Tripwire alarm front end
// Accepts items, classifies the command byte and holds them in a short queue.
// ----------------------------------------------------------------------------
module tac_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tac_pkg::in_item_t in_data_i,
  output logic             q_valid_o,
  output tac_pkg::q_entry_t q_data_o,
  input  logic             q_pop_i
);
  import tac_pkg::*;

  q_entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  q_entry_t            entry;
  logic                push;
  logic                pop;

  always_comb begin
    entry.light_sample = in_data_i.light_sample;
    entry.rx_byte      = in_data_i.rx_byte;
    entry.digit        = 4'(in_data_i.rx_byte - CH_ZERO);
    if (!in_data_i.byte_valid) begin
      entry.cls = BC_NONE;
    end else begin
      unique case (in_data_i.rx_byte) inside
        CH_COLON:           entry.cls = BC_COLON;
        CH_COMMA:           entry.cls = BC_COMMA;
        [CH_ZERO:CH_NINE]:  entry.cls = BC_DIGIT;
        default:            entry.cls = BC_OTHER;
      endcase
    end
  end

  assign in_stall_o = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (count_q != '0);
  assign q_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

>>> hdl/tac_back.sv
// ----------------------------------------------------------------------------
// Tripwire alarm back end
// Runs one loop tick per queued item: beam check, request timer, command
// parser and decoder, mode machine, and the registered result.
// ----------------------------------------------------------------------------
module tac_back #(
  parameter int DIGIT_LIMIT = tac_pkg::DIGIT_LIMIT_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tac_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [tac_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               q_valid_i,
  input  tac_pkg::q_entry_t                  q_data_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tac_pkg::out_item_t                 out_data_o
);
  import tac_pkg::*;

  localparam int SUM_W  = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + 1;
  localparam int ACC_W  = NUM_W + 4;
  localparam int PROD_W = NUM_W + 8;

  // Configuration registers.
  logic [LEVEL_W-1:0]  baseline_q;
  logic [LEVEL_W-1:0]  margin_q;
  logic [PERIOD_W-1:0] period_q;

  // Tick state.
  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [PERIOD_W-1:0]    tick_q, tick_d;
  phase_e                 phase_q, phase_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [CHAR_W-1:0]      let_first_q, let_first_d;
  logic [CHAR_W-1:0]      let_mid_q, let_mid_d;
  logic [CHAR_W-1:0]      let_late_q, let_late_d;
  logic [NUM_W-1:0]       hour_q, hour_d;
  logic [NUM_W-1:0]       minute_q, minute_d;
  logic [NUM_W-1:0]       acc_q, acc_d;
  logic [CLOCK_W-1:0]     clock_q, clock_d;
  logic [NUM_W-1:0]       start_q, start_d;
  logic [NUM_W-1:0]       end_q, end_d;
  logic                   wraps_q, wraps_d;
  mode_e                  mode_q, mode_d;

  logic                   out_valid_q;
  out_item_t              out_q, out_d;

  logic                   pop;
  logic                   trig;
  logic                   treq;
  logic                   err;
  logic                   help;
  logic                   done;
  logic                   clear;
  logic                   in_win;
  alert_e                 alert;
  logic [PERIOD_W-1:0]    tick_inc;
  logic [ACC_W-1:0]       acc_next;
  logic [PROD_W-1:0]      t_val;
  logic [NUM_W-1:0]       keep_val;
  logic                   is_delim;

  assign pop         = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o     = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    prev_d      = q_data_i.light_sample;
    phase_d     = phase_q;
    pos_d       = pos_q;
    let_first_d = let_first_q;
    let_mid_d   = let_mid_q;
    let_late_d  = let_late_q;
    hour_d      = hour_q;
    minute_d    = minute_q;
    acc_d       = acc_q;
    clock_d     = clock_q;
    end_d       = end_q;
    mode_d      = mode_q;
    done        = 1'b0;
    clear       = 1'b0;
    err         = 1'b0;
    help        = 1'b0;
    alert       = ALERT_NONE;
    t_val       = '0;

    trig = (SUM_W'(prev_q) + SUM_W'(margin_q)) < SUM_W'(baseline_q);

    tick_inc = tick_q + 1'b1;
    treq     = (tick_inc >= period_q);
    tick_d   = treq ? '0 : tick_inc;

    // The wrap flag looks at the window as it stood before this item.
    if (end_q < start_q) begin
      wraps_d = 1'b1;
    end else if (end_q > start_q) begin
      wraps_d = 1'b0;
    end else begin
      wraps_d = wraps_q;
    end
    start_d = (start_q == '0) ? MIDNIGHT : start_q;

    acc_next = (ACC_W'(acc_q) << 3) + (ACC_W'(acc_q) << 1) + ACC_W'(q_data_i.digit);
    is_delim = (q_data_i.cls == BC_COLON) || (q_data_i.cls == BC_COMMA);
    keep_val = '0;

    // Command parser: one byte per item.
    if (q_data_i.cls != BC_NONE) begin
      unique case (phase_q)
        PH_WORD: begin
          if (is_delim) begin
            // A terminator clears the kept letter at its own position.
            if (pos_q == POS_FIRST) begin
              let_first_d = '0;
            end else if (pos_q == POS_MIDDLE) begin
              let_mid_d = '0;
            end else if (pos_q == POS_LATE) begin
              let_late_d = '0;
            end
            acc_d = '0;
            pos_d = '0;
            if (q_data_i.cls == BC_COLON) begin
              phase_d = PH_HOUR;
            end else begin
              done = 1'b1;
            end
          end else begin
            if (pos_q == POS_FIRST) begin
              let_first_d = q_data_i.rx_byte;
            end else if (pos_q == POS_MIDDLE) begin
              let_mid_d = q_data_i.rx_byte;
            end else if (pos_q == POS_LATE) begin
              let_late_d = q_data_i.rx_byte;
            end
            if (pos_q < POS_SAT) begin
              pos_d = pos_q + 1'b1;
            end
          end
        end
        PH_HOUR, PH_MINUTE: begin
          if (is_delim) begin
            if (phase_q == PH_HOUR) begin
              hour_d = acc_q;
            end else begin
              minute_d = acc_q;
            end
            acc_d = '0;
            pos_d = '0;
            if (q_data_i.cls == BC_COMMA) begin
              phase_d = PH_WORD;
              done    = 1'b1;
            end else if (phase_q == PH_HOUR) begin
              phase_d = PH_MINUTE;
            end else begin
              phase_d = PH_SECOND;
            end
          end else if (pos_q < POS_W'(DIGIT_LIMIT)) begin
            if (q_data_i.cls == BC_DIGIT) begin
              acc_d = (acc_next > ACC_W'(NUM_SAT)) ? NUM_SAT : acc_next[NUM_W-1:0];
              pos_d = pos_q + 1'b1;
            end else begin
              pos_d = POS_W'(DIGIT_LIMIT);
            end
          end
        end
        PH_SECOND: begin
          if (q_data_i.cls == BC_COMMA) begin
            acc_d   = '0;
            pos_d   = '0;
            phase_d = PH_WORD;
            done    = 1'b1;
          end
        end
        default: begin
          phase_d = PH_WORD;
        end
      endcase
    end

    // Command decoder, on the letters and values as they stand after the byte.
    if (done) begin
      unique case (let_first_d)
        CH_M: begin
          if ((hour_d >= NUM_W'(1)) && (hour_d <= NUM_W'(3))) begin
            mode_d = mode_e'(hour_d[1:0] - 2'd1);
          end else begin
            mode_d = MODE_AUTO;
          end
        end
        CH_C: help = 1'b1;
        CH_R: clear = 1'b1;
        CH_T: begin
          t_val = PROD_W'(hour_d) * PROD_W'(HOUR_SCALE) + PROD_W'(minute_d);
          if (t_val > PROD_W'(MIDNIGHT)) begin
            treq    = 1'b1;
            clock_d = (t_val > PROD_W'(CLOCK_MAX)) ? CLOCK_W'(CLOCK_MAX)
                                                   : t_val[CLOCK_W-1:0];
          end else if (t_val == PROD_W'(MIDNIGHT)) begin
            clock_d = '0;
          end else begin
            clock_d = t_val[CLOCK_W-1:0];
            clear   = 1'b1;
          end
        end
        default: begin
          if ((let_late_d == CH_E) && (let_mid_d == CH_A)) begin
            end_d = hour_d;
            clear = 1'b1;
          end else if ((let_late_d == CH_S) && (let_mid_d == CH_A)) begin
            start_d = hour_d;
            clear   = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
      endcase
    end

    if (clear) begin
      let_first_d = '0;
      hour_d      = '0;
      minute_d    = '0;
    end

    keep_val = NUM_W'(clock_d);
    if (wraps_d) begin
      in_win = (keep_val >= start_d) || (keep_val < end_d);
    end else begin
      in_win = (keep_val >= start_d) && (keep_val < end_d);
    end

    // Mode machine.
    unique case (mode_d)
      MODE_DEMO: begin
        if (trig) begin
          alert  = ALERT_DEMO;
          mode_d = MODE_DISARMED;
        end
      end
      MODE_ARMED: begin
        if (trig) begin
          alert = ALERT_ARMED;
        end
      end
      MODE_DISARMED: begin
        if (in_win) begin
          mode_d = MODE_AUTO;
        end
      end
      MODE_AUTO: begin
        if (in_win) begin
          if (trig) begin
            alert = ALERT_AUTO;
          end
        end else begin
          mode_d = MODE_DISARMED;
        end
      end
      default: mode_d = MODE_AUTO;
    endcase

    out_d.beam_broken   = trig;
    out_d.alert_kind    = alert;
    out_d.time_request  = treq;
    out_d.command_error = err;
    out_d.help_request  = help;
    out_d.alarm_mode    = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= '0;
      margin_q   <= MARGIN_RESET;
      period_q   <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASELINE: baseline_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_MARGIN:   margin_q   <= cfg_data_i[LEVEL_W-1:0];
        CFG_PERIOD:   period_q   <= cfg_data_i[PERIOD_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      tick_q      <= '0;
      phase_q     <= PH_WORD;
      pos_q       <= '0;
      let_first_q <= '0;
      let_mid_q   <= '0;
      let_late_q  <= '0;
      hour_q      <= '0;
      minute_q    <= '0;
      acc_q       <= '0;
      clock_q     <= '0;
      start_q     <= START_RESET;
      end_q       <= END_RESET;
      wraps_q     <= 1'b0;
      mode_q      <= MODE_AUTO;
    end else if (pop) begin
      prev_q      <= prev_d;
      tick_q      <= tick_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      let_first_q <= let_first_d;
      let_mid_q   <= let_mid_d;
      let_late_q  <= let_late_d;
      hour_q      <= hour_d;
      minute_q    <= minute_d;
      acc_q       <= acc_d;
      clock_q     <= clock_d;
      start_q     <= start_d;
      end_q       <= end_d;
      wraps_q     <= wraps_d;
      mode_q      <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Tripwire alarm command controller testbench
// Drives loop ticks that carry light samples and command bytes. A tick-by-tick
// predictor of the beam check, parser and mode machine produces the expected
// result of every accepted tick, and each returned result is checked field by
// field. Sender and receiver idle at random in changing proportions, and the
// three registers are set to several values between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import tac_pkg::*;

  localparam int DIGITS      = DIGIT_LIMIT_DEFAULT;
  localparam int STALL_LIMIT = 3000;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = CFG_BASELINE;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  in_item_t               in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  out_item_t              out_data_o;

  tripwire_alarm_command_controller #(
    .DIGIT_LIMIT(DIGITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor copy of the registers and state.
  logic [LEVEL_W-1:0]  m_baseline;
  logic [LEVEL_W-1:0]  m_margin;
  logic [PERIOD_W-1:0] m_period;
  logic [LEVEL_W-1:0]  m_prev;
  logic [PERIOD_W-1:0] m_ticks;
  phase_e              m_phase;
  logic [POS_W-1:0]    m_pos;
  logic [CHAR_W-1:0]   m_first;
  logic [CHAR_W-1:0]   m_mid;
  logic [CHAR_W-1:0]   m_late;
  logic [NUM_W-1:0]    m_hour;
  logic [NUM_W-1:0]    m_minute;
  logic [NUM_W-1:0]    m_acc;
  logic [CLOCK_W-1:0]  m_clock;
  logic [NUM_W-1:0]    m_wstart;
  logic [NUM_W-1:0]    m_wend;
  logic                m_wraps;
  mode_e               m_mode;

  out_item_t         expected_reports[$];
  out_item_t         want;
  logic [CHAR_W-1:0] command_bytes[$];

  int send_idle_pct  = 31;
  int stall_pct      = 46;
  int ticks_sent     = 0;
  int results_seen   = 0;
  int commands_done  = 0;
  int alerts_due     = 0;
  int requests_due   = 0;
  int mismatch_count = 0;
  int idle_cycles    = 0;

  function automatic void keep_letter(logic [POS_W-1:0] pos, logic [CHAR_W-1:0] ch);
    if (pos == POS_FIRST) m_first = ch;
    else if (pos == POS_MIDDLE) m_mid = ch;
    else if (pos == POS_LATE) m_late = ch;
  endfunction

  function automatic void forget_command();
    m_first  = '0;
    m_hour   = '0;
    m_minute = '0;
  endfunction

  function automatic out_item_t advance_tick(in_item_t item);
    out_item_t         r;
    logic              trig;
    logic              treq;
    logic              err;
    logic              help;
    logic              done;
    logic              in_win;
    alert_e            alert;
    logic [CHAR_W-1:0] ch;
    int                t;
    int                v;
    treq  = 1'b0;
    err   = 1'b0;
    help  = 1'b0;
    done  = 1'b0;
    alert = ALERT_NONE;
    // The beam check looks at the sample of the previous tick.
    trig   = (int'(m_prev) + int'(m_margin)) < int'(m_baseline);
    m_prev = item.light_sample;
    m_ticks = m_ticks + 16'd1;
    // The wrap flag follows the window as it stood before this tick's byte.
    if (m_wend < m_wstart) m_wraps = 1'b1;
    if (m_wend > m_wstart) m_wraps = 1'b0;
    if (m_ticks >= m_period) begin
      treq    = 1'b1;
      m_ticks = '0;
    end
    if (m_wstart == '0) m_wstart = MIDNIGHT;

    if (item.byte_valid) begin
      ch = item.rx_byte;
      case (m_phase)
        PH_WORD: begin
          if (ch == CH_COLON || ch == CH_COMMA) begin
            keep_letter(m_pos, '0);
            m_acc = '0;
            m_pos = '0;
            if (ch == CH_COLON) m_phase = PH_HOUR;
            else done = 1'b1;
          end else begin
            keep_letter(m_pos, ch);
            if (m_pos != POS_SAT) m_pos = m_pos + 1'b1;
          end
        end
        PH_HOUR, PH_MINUTE: begin
          if (ch == CH_COLON || ch == CH_COMMA) begin
            if (m_phase == PH_HOUR) m_hour = m_acc;
            else m_minute = m_acc;
            m_acc = '0;
            m_pos = '0;
            if (ch == CH_COMMA) begin
              m_phase = PH_WORD;
              done    = 1'b1;
            end else begin
              m_phase = (m_phase == PH_HOUR) ? PH_MINUTE : PH_SECOND;
            end
          end else if (m_pos < POS_W'(DIGITS)) begin
            // Any non-digit closes the number; later digits are ignored.
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
              v     = int'(m_acc) * 10 + int'(ch - CH_ZERO);
              m_acc = (v > int'(NUM_SAT)) ? NUM_SAT : NUM_W'(v);
              m_pos = m_pos + 1'b1;
            end else begin
              m_pos = POS_W'(DIGITS);
            end
          end
        end
        default: begin
          if (ch == CH_COMMA) begin
            m_acc   = '0;
            m_pos   = '0;
            m_phase = PH_WORD;
            done    = 1'b1;
          end
        end
      endcase
    end

    if (done) begin
      commands_done++;
      if (m_first == CH_M) begin
        case (m_hour)
          NUM_W'(1): m_mode = MODE_DEMO;
          NUM_W'(2): m_mode = MODE_ARMED;
          NUM_W'(3): m_mode = MODE_DISARMED;
          default:   m_mode = MODE_AUTO;
        endcase
      end else if (m_first == CH_C) begin
        help = 1'b1;
      end else if (m_first == CH_R) begin
        forget_command();
      end else if (m_first == CH_T) begin
        t = HOUR_SCALE * int'(m_hour) + int'(m_minute);
        if (t > int'(MIDNIGHT)) begin
          treq    = 1'b1;
          m_clock = (t > CLOCK_MAX) ? CLOCK_W'(CLOCK_MAX) : CLOCK_W'(t);
        end else if (t == int'(MIDNIGHT)) begin
          m_clock = '0;
        end else begin
          m_clock = CLOCK_W'(t);
          forget_command();
        end
      end else if (m_late == CH_E && m_mid == CH_A) begin
        m_wend = m_hour;
        forget_command();
      end else if (m_late == CH_S && m_mid == CH_A) begin
        m_wstart = m_hour;
        forget_command();
      end else begin
        err = 1'b1;
      end
    end

    if (m_wraps) in_win = (m_clock >= m_wstart) || (m_clock < m_wend);
    else in_win = (m_clock >= m_wstart) && (m_clock < m_wend);

    case (m_mode)
      MODE_DEMO: begin
        if (trig) begin
          alert  = ALERT_DEMO;
          m_mode = MODE_DISARMED;
        end
      end
      MODE_ARMED: begin
        if (trig) alert = ALERT_ARMED;
      end
      MODE_DISARMED: begin
        if (in_win) m_mode = MODE_AUTO;
      end
      default: begin
        if (!in_win) m_mode = MODE_DISARMED;
        else if (trig) alert = ALERT_AUTO;
      end
    endcase

    if (alert != ALERT_NONE) alerts_due++;
    if (treq) requests_due++;
    r.beam_broken   = trig;
    r.alert_kind    = alert;
    r.time_request  = treq;
    r.command_error = err;
    r.help_request  = help;
    r.alarm_mode    = m_mode;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [1:0] seen, logic [1:0] due);
    if (seen !== due) begin
      report_mismatch($sformatf("result %0d: %s is %0d, predicted %0d",
                                results_seen, name, seen, due));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing predicted", results_seen));
      end else begin
        want = expected_reports.pop_front();
        check_field("beam_broken", 2'(out_data_o.beam_broken), 2'(want.beam_broken));
        check_field("alert_kind", out_data_o.alert_kind, want.alert_kind);
        check_field("time_request", 2'(out_data_o.time_request), 2'(want.time_request));
        check_field("command_error", 2'(out_data_o.command_error),
                    2'(want.command_error));
        check_field("help_request", 2'(out_data_o.help_request), 2'(want.help_request));
        check_field("alarm_mode", out_data_o.alarm_mode, want.alarm_mode);
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_light();
    int centre;
    int v;
    case ($urandom_range(9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return SAMPLE_BITS'($urandom_range(1023));
      default: begin
        // Hover around the trip threshold.
        centre = int'(m_baseline) - int'(m_margin);
        v      = centre + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return SAMPLE_BITS'(v);
      end
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] any_letter();
    return CH_A + CHAR_W'($urandom_range(25));
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) command_bytes.push_back(s[i]);
  endfunction

  function automatic string field_text(int typical_max);
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return "";
    if (roll < 14) return $sformatf("%0dx%0d", $urandom_range(9), $urandom_range(9));
    if (roll < 24) return "0";
    if (roll < 36) return $sformatf("%0d", $urandom_range(99999));
    return $sformatf("%0d", $urandom_range(typical_max));
  endfunction

  // Appends the optional hour, minute and seconds fields and the comma.
  function automatic void push_fields(int hour_max, int minute_max);
    int depth;
    depth = $urandom_range(9);
    if (depth > 0) begin
      push_text({":", field_text(hour_max)});
      if (depth > 2) begin
        push_text({":", field_text(minute_max)});
        if (depth > 5) push_text({":", field_text(99)});
      end
    end
    push_text(",");
  endfunction

  function automatic void compose_command();
    int kind;
    int len;
    int i;
    kind = $urandom_range(99);
    if (kind < 18) begin
      push_text("m");
      repeat ($urandom_range(3)) command_bytes.push_back(any_letter());
      push_fields(4, 59);
    end else if (kind < 27) begin
      push_text("c");
      repeat ($urandom_range(3)) command_bytes.push_back(any_letter());
      push_fields(9, 9);
    end else if (kind < 35) begin
      push_text("r");
      push_fields(9, 9);
    end else if (kind < 55) begin
      push_text("t");
      push_fields(24, 59);
    end else if (kind < 75) begin
      // Window words are told apart by their fifth and thirteenth letters.
      len = ($urandom_range(7) == 0) ? $urandom_range(30, 36) : $urandom_range(13, 16);
      for (i = 0; i < len; i++) begin
        if (i == 0) command_bytes.push_back(CH_S);
        else if (i == 4) command_bytes.push_back(CH_A);
        else if (i == 12) begin
          case ($urandom_range(4))
            0, 1:    command_bytes.push_back(CH_E);
            2, 3:    command_bytes.push_back(CH_S);
            default: command_bytes.push_back(any_letter());
          endcase
        end else command_bytes.push_back(any_letter());
      end
      push_fields(2400, 59);
    end else if (kind < 88) begin
      repeat ($urandom_range(1, 6)) command_bytes.push_back(any_letter());
      push_fields(99, 99);
    end else begin
      // Loose bytes, often with no closing comma.
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(4))
          0:       command_bytes.push_back(CHAR_W'($urandom_range(255)));
          1:       command_bytes.push_back(CH_COLON);
          2:       command_bytes.push_back(CH_COMMA);
          3:       command_bytes.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
          default: command_bytes.push_back(any_letter());
        endcase
      end
    end
  endfunction

  task automatic send_tick(logic [SAMPLE_BITS-1:0] light, logic byte_in,
                           logic [CHAR_W-1:0] ch);
    in_item_t item;
    item.light_sample = light;
    item.byte_valid   = byte_in;
    item.rx_byte      = ch;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_reports.push_back(advance_tick(item));
    ticks_sent++;
  endtask

  task automatic send_quiet();
    send_tick(pick_light(), 1'b0, CHAR_W'($urandom_range(255)));
  endtask

  task automatic send_bytes(int quiet_pct);
    logic [CHAR_W-1:0] ch;
    while (command_bytes.size() != 0) begin
      if ($urandom_range(99) < quiet_pct) send_quiet();
      ch = command_bytes.pop_front();
      send_tick(pick_light(), 1'b1, ch);
    end
  endtask

  task automatic send_text(string s);
    push_text(s);
    send_bytes(0);
  endtask

  task automatic write_register(cfg_index_e idx, logic [CFG_DATA_W-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BASELINE: m_baseline = value[LEVEL_W-1:0];
      CFG_MARGIN:   m_margin   = value[LEVEL_W-1:0];
      default:      m_period   = value;
    endcase
  endtask

  task automatic test_reset_values();
    m_baseline = '0;
    m_margin   = MARGIN_RESET;
    m_period   = PERIOD_RESET;
    m_prev     = '0;
    m_ticks    = '0;
    m_phase    = PH_WORD;
    m_pos      = '0;
    m_first    = '0;
    m_mid      = '0;
    m_late     = '0;
    m_hour     = '0;
    m_minute   = '0;
    m_acc      = '0;
    m_clock    = '0;
    m_wstart   = START_RESET;
    m_wend     = END_RESET;
    m_wraps    = 1'b0;
    m_mode     = MODE_AUTO;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    repeat (3) send_quiet();
  endtask

  task automatic test_directed_commands();
    write_register(CFG_BASELINE, 16'd600);
    send_tick('1, 1'b0, 8'hFF);
    send_tick('0, 1'b0, 8'h00);
    send_tick('0, 1'b1, 8'h00);
    send_tick('1, 1'b1, 8'hFF);
    send_text(",");
    send_text("c,");
    // Demo mode: the first broken beam raises the alert and disarms.
    send_text("m:1,");
    send_tick('0, 1'b0, 8'h5A);
    send_tick('1, 1'b0, 8'hA5);
    send_text("t:25,");
    send_text("t:24,");
    send_text("r,");
  endtask

  task automatic test_register_extremes();
    write_register(CFG_PERIOD, 16'd0);
    repeat (3) send_quiet();
    write_register(CFG_PERIOD, 16'd1);
    repeat (3) send_quiet();
    write_register(CFG_PERIOD, 16'hFFFF);
    // Bits above the level width are dropped.
    write_register(CFG_BASELINE, 16'hFFFF);
    write_register(CFG_MARGIN, 16'd0);
    send_tick('0, 1'b0, 8'h00);
    send_tick('1, 1'b0, 8'hFF);
    send_quiet();
    write_register(CFG_MARGIN, 16'h03FF);
    repeat (3) send_quiet();
    write_register(CFG_BASELINE, 16'd0);
    repeat (3) send_quiet();
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, logic [CFG_DATA_W-1:0] base,
                                     logic [CFG_DATA_W-1:0] margin,
                                     logic [CFG_DATA_W-1:0] period, int quota);
    int target;
    write_register(CFG_BASELINE, base);
    write_register(CFG_MARGIN, margin);
    write_register(CFG_PERIOD, period);
    send_idle_pct = tx_pct;
    stall_pct     = rx_pct;
    target        = ticks_sent + quota;
    while (ticks_sent < target) begin
      compose_command();
      send_bytes(15);
    end
  endtask

  initial begin
    test_reset_values();
    test_directed_commands();
    test_register_extremes();
    test_random_traffic(31, 46, 16'd700, 16'd30, 16'd37, 320);
    test_random_traffic(46, 31, 16'd1023, 16'd0, 16'd250, 320);
    test_random_traffic(0, 0, 16'd400, 16'd100, 16'd65535, 300);
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("run covered %0d ticks, %0d checked results and %0d completed commands",
             ticks_sent, results_seen, commands_done);
    $display("predicted %0d alerts and %0d time requests", alerts_due, requests_due);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tac_pkg.sv
hdl/tac_front.sv
hdl/tac_back.sv
hdl/tripwire_alarm_command_controller.sv
tb/tb_top.sv
